// ===== sv/vrn_pkg.sv =====
// shared types and constants for the vector reflect and normalise pipeline
// no dependencies
`default_nettype none

package vrn_pkg;

    localparam int QW        = 32;
    localparam int FRAC      = 16;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int NUM_W     = QW + FRAC;
    localparam int LANES     = 3;

    // per-item data that rides alongside the pipelined square root and divider
    typedef struct packed {
        logic                       ovf;
        logic                       zero;
        logic [LANES-1:0][QW-1:0]   r;
    } side_t;

endpackage

`default_nettype wire

// ===== sv/vrn_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on vrn_pkg
`default_nettype none

module vrn_sqrt
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        vld_in,
    input  wire logic [vrn_pkg::SQ_W-1:0]    x_in,
    input  wire vrn_pkg::side_t              side_in,
    output logic                             vld_out,
    output logic [vrn_pkg::ROOT_W-1:0]       root_out,
    output vrn_pkg::side_t                   side_out
);

    localparam int N   = vrn_pkg::ROOT_W;
    localparam int RW  = vrn_pkg::ROOT_W + 3;

    logic [vrn_pkg::SQ_W-1:0]   x_reg    [N];
    logic [RW-1:0]              rem_reg  [N];
    logic [N-1:0]               root_reg [N];
    vrn_pkg::side_t             side_reg [N];
    logic [N-1:0]               vld_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [vrn_pkg::SQ_W-1:0]   x_cur;
        logic [RW-1:0]              rem_cur;
        logic [N-1:0]               root_cur;
        vrn_pkg::side_t             side_cur;
        logic                       vld_cur;
        logic [RW-1:0]              rem_cat;
        logic [RW-1:0]              trial;
        logic                       take;

        if (k == 0)
        begin : g_first
            assign x_cur    = x_in;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
            assign vld_cur  = vld_in;
        end
        else
        begin : g_next
            assign x_cur    = x_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_cat = {rem_cur[RW-3:0], x_cur[vrn_pkg::SQ_W-1 -: 2]};
        assign trial   = {1'b0, root_cur, 2'b01};
        assign take    = (rem_cat >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= {x_cur[vrn_pkg::SQ_W-3:0], 2'b00};
                rem_reg[k]  <= take ? (rem_cat - trial) : rem_cat;
                root_reg[k] <= {root_cur[N-2:0], take};
                side_reg[k] <= side_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end
    end

    assign vld_out  = vld_reg[N-1];
    assign root_out = root_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/vrn_div.sv =====
// pipelined restoring divider, three lanes sharing one divisor, one bit per stage
// depends on vrn_pkg
`default_nettype none

module vrn_div
(
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            en,
    input  wire logic                                            vld_in,
    input  wire logic [vrn_pkg::LANES-1:0][vrn_pkg::NUM_W-1:0]   num_in,
    input  wire logic [vrn_pkg::QW-1:0]                          den_in,
    input  wire vrn_pkg::side_t                                  side_in,
    output logic                                                 vld_out,
    output logic [vrn_pkg::LANES-1:0][vrn_pkg::NUM_W-1:0]        quot_out,
    output vrn_pkg::side_t                                       side_out
);

    localparam int N  = vrn_pkg::NUM_W;
    localparam int QW = vrn_pkg::QW;
    localparam int L  = vrn_pkg::LANES;

    logic [L-1:0][N-1:0]    num_reg  [N];
    logic [L-1:0][QW-1:0]   rem_reg  [N];
    logic [QW-1:0]          den_reg  [N];
    vrn_pkg::side_t         side_reg [N];
    logic [N-1:0]           vld_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [L-1:0][N-1:0]    num_cur;
        logic [L-1:0][QW-1:0]   rem_cur;
        logic [QW-1:0]          den_cur;
        vrn_pkg::side_t         side_cur;
        logic                   vld_cur;
        logic [L-1:0][N-1:0]    num_nx;
        logic [L-1:0][QW-1:0]   rem_nx;

        if (k == 0)
        begin : g_first
            assign num_cur  = num_in;
            assign rem_cur  = '0;
            assign den_cur  = den_in;
            assign side_cur = side_in;
            assign vld_cur  = vld_in;
        end
        else
        begin : g_next
            assign num_cur  = num_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign den_cur  = den_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // quotient bits shift in where the dividend bits shift out
        always_comb
        begin
            logic [QW:0] cat;
            for (int i = 0; i < L; i++)
            begin
                cat = {rem_cur[i], num_cur[i][N-1]};
                if (cat >= {1'b0, den_cur})
                begin
                    cat       = cat - {1'b0, den_cur};
                    num_nx[i] = {num_cur[i][N-2:0], 1'b1};
                end
                else
                begin
                    num_nx[i] = {num_cur[i][N-2:0], 1'b0};
                end
                rem_nx[i] = cat[QW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= num_nx;
                rem_reg[k]  <= rem_nx;
                den_reg[k]  <= den_cur;
                side_reg[k] <= side_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end
    end

    assign vld_out  = vld_reg[N-1];
    assign quot_out = num_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/vector_reflect_normalize_top.sv =====
// throughput: one beat per cycle; the 32-stage square root and the 48-stage
//   divider are fully pipelined, so the whole chain advances together
// a stall at the output freezes every stage; s_axis_tready follows it
// reset: asynchronous active low, clears all valid bits, data is not reset
// depends on vrn_pkg, vrn_sqrt, vrn_div
`default_nettype none

module vector_reflect_normalize_top
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z (32 bits each, lowest first)
    input  wire logic [191:0]   s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // refl_x, refl_y, refl_z (32 bits each, lowest first)
    output logic [95:0]         m_axis_tdata,
    // zero_length, overflowed (lowest first)
    output logic [1:0]          m_axis_tuser
);

    localparam int QW = vrn_pkg::QW;
    localparam int L  = vrn_pkg::LANES;
    localparam int FW = 50;             // wide enough for any sum before saturation

    localparam logic signed [FW-1:0] QMAX = FW'(64'sh7FFF_FFFF);
    localparam logic signed [FW-1:0] QMIN = -FW'(64'sh8000_0000);
    localparam logic [vrn_pkg::NUM_W-1:0] NEG_LIM = vrn_pkg::NUM_W'(64'h8000_0000);
    localparam logic [vrn_pkg::NUM_W-1:0] POS_LIM = vrn_pkg::NUM_W'(64'h7FFF_FFFF);

    // product divided by 2^16, rounding toward zero
    function automatic logic signed [FW-1:0] trunc_q(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sd65535 : 64'sd0);
        return FW'(adj >>> vrn_pkg::FRAC);
    endfunction

    function automatic logic sat_ovf(input logic signed [FW-1:0] v);
        return (v > QMAX) || (v < QMIN);
    endfunction

    function automatic logic signed [QW-1:0] sat_val(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] c;
        c = (v > QMAX) ? QMAX : ((v < QMIN) ? QMIN : v);
        return c[QW-1:0];
    endfunction

    // whole pipe moves when the output register is free or being drained
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 1: input products a*n
    logic signed [QW-1:0]   a_in [L];
    logic signed [QW-1:0]   n_in [L];
    logic signed [QW-1:0]   a1_reg [L];
    logic signed [QW-1:0]   n1_reg [L];
    logic signed [63:0]     p1_reg [L];
    logic                   vld1_reg;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            a_in[i] = $signed(s_axis_tdata[QW*i +: QW]);
            n_in[i] = $signed(s_axis_tdata[QW*(L+i) +: QW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < L; i++)
            begin
                a1_reg[i] <= a_in[i];
                n1_reg[i] <= n_in[i];
                p1_reg[i] <= a_in[i] * n_in[i];
            end
        end
    end

    // ---------------- stage 2: dot product and doubled normal, saturated
    logic signed [QW-1:0]   a2_reg [L];
    logic signed [QW-1:0]   dn2_reg [L];
    logic signed [QW-1:0]   dot2_reg;
    logic                   ovf2_reg;
    logic                   vld2_reg;
    logic signed [FW-1:0]   dot_sum;
    logic signed [FW-1:0]   dn_wide [L];
    logic                   ovf2_next;

    always_comb
    begin
        dot_sum   = trunc_q(p1_reg[0]) + trunc_q(p1_reg[1]) + trunc_q(p1_reg[2]);
        ovf2_next = sat_ovf(dot_sum);
        for (int i = 0; i < L; i++)
        begin
            dn_wide[i] = FW'(n1_reg[i]) <<< 1;
            ovf2_next  = ovf2_next | sat_ovf(dn_wide[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot2_reg <= sat_val(dot_sum);
            ovf2_reg <= ovf2_next;
            for (int i = 0; i < L; i++)
            begin
                a2_reg[i]  <= a1_reg[i];
                dn2_reg[i] <= sat_val(dn_wide[i]);
            end
        end
    end

    // ---------------- stage 3: scaled normal products 2n*dot
    logic signed [QW-1:0]   a3_reg [L];
    logic signed [63:0]     q3_reg [L];
    logic                   ovf3_reg;
    logic                   vld3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf3_reg <= ovf2_reg;
            for (int i = 0; i < L; i++)
            begin
                a3_reg[i] <= a2_reg[i];
                q3_reg[i] <= dn2_reg[i] * dot2_reg;
            end
        end
    end

    // ---------------- stage 4: reflected vector r = a - sc
    logic signed [QW-1:0]   r4_reg [L];
    logic                   ovf4_reg;
    logic                   vld4_reg;
    logic signed [FW-1:0]   sc_wide [L];
    logic signed [FW-1:0]   r_wide [L];
    logic signed [QW-1:0]   r_sat [L];
    logic                   ovf4_next;

    always_comb
    begin
        ovf4_next = ovf3_reg;
        for (int i = 0; i < L; i++)
        begin
            sc_wide[i] = trunc_q(q3_reg[i]);
            ovf4_next  = ovf4_next | sat_ovf(sc_wide[i]);
            r_wide[i]  = FW'(a3_reg[i]) - FW'(sat_val(sc_wide[i]));
            ovf4_next  = ovf4_next | sat_ovf(r_wide[i]);
            r_sat[i]   = sat_val(r_wide[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf4_reg <= ovf4_next;
            for (int i = 0; i < L; i++)
            begin
                r4_reg[i] <= r_sat[i];
            end
        end
    end

    // ---------------- stage 5: squares of magnitudes
    logic [QW-1:0]          mag4 [L];
    logic signed [QW-1:0]   r5_reg [L];
    logic [63:0]            sq5_reg [L];
    logic                   ovf5_reg;
    logic                   vld5_reg;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            mag4[i] = r4_reg[i][QW-1] ? (QW'(0) - r4_reg[i]) : r4_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf5_reg <= ovf4_reg;
            for (int i = 0; i < L; i++)
            begin
                r5_reg[i]  <= r4_reg[i];
                sq5_reg[i] <= mag4[i] * mag4[i];
            end
        end
    end

    // ---------------- stage 6: sum of squares, fits in 64 bits
    logic [63:0]            sum6_reg;
    vrn_pkg::side_t         side6_reg;
    logic                   vld6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum6_reg       <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            side6_reg.ovf  <= ovf5_reg;
            side6_reg.zero <= 1'b0;
            for (int i = 0; i < L; i++)
            begin
                side6_reg.r[i] <= r5_reg[i];
            end
        end
    end

    // ---------------- square root
    logic                           sq_vld;
    logic [vrn_pkg::ROOT_W-1:0]     sq_root;
    vrn_pkg::side_t                 sq_side;

    vrn_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld6_reg),
        .x_in     (sum6_reg),
        .side_in  (side6_reg),
        .vld_out  (sq_vld),
        .root_out (sq_root),
        .side_out (sq_side)
    );

    // ---------------- stage 7: length clamp, zero test, dividends
    logic [QW-1:0]                                  len7_reg;
    vrn_pkg::side_t                                 side7_reg;
    logic [L-1:0][vrn_pkg::NUM_W-1:0]               num7_reg;
    logic                                           vld7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // root above the signed range saturates the length
            len7_reg       <= sq_root[QW-1] ? QW'(QMAX) : sq_root;
            side7_reg.ovf  <= sq_side.ovf | sq_root[QW-1];
            side7_reg.zero <= (sq_root == '0);
            side7_reg.r    <= sq_side.r;
            for (int i = 0; i < L; i++)
            begin
                num7_reg[i] <= {(sq_side.r[i][QW-1] ? (QW'(0) - sq_side.r[i])
                                                    : sq_side.r[i]),
                                vrn_pkg::FRAC'(0)};
            end
        end
    end

    // ---------------- divide
    logic                               dv_vld;
    logic [L-1:0][vrn_pkg::NUM_W-1:0]   dv_quot;
    vrn_pkg::side_t                     dv_side;

    vrn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld7_reg),
        .num_in   (num7_reg),
        .den_in   (len7_reg),
        .side_in  (side7_reg),
        .vld_out  (dv_vld),
        .quot_out (dv_quot),
        .side_out (dv_side)
    );

    // ---------------- stage 8: sign, saturation, output register
    logic [L-1:0][QW-1:0]   res_next;
    logic                   ovf8_next;
    logic [95:0]            tdata_reg;
    logic [1:0]             tuser_reg;
    logic                   tvalid_reg;

    always_comb
    begin
        ovf8_next = dv_side.ovf;
        for (int i = 0; i < L; i++)
        begin
            if (dv_side.zero)
            begin
                // zero-length vector passes through unnormalised
                res_next[i] = dv_side.r[i];
            end
            else if (dv_side.r[i][QW-1])
            begin
                if (dv_quot[i] > NEG_LIM)
                begin
                    res_next[i] = QW'(QMIN);
                    ovf8_next   = 1'b1;
                end
                else
                begin
                    res_next[i] = QW'(0) - dv_quot[i][QW-1:0];
                end
            end
            else
            begin
                if (dv_quot[i] > POS_LIM)
                begin
                    res_next[i] = QW'(QMAX);
                    ovf8_next   = 1'b1;
                end
                else
                begin
                    res_next[i] = dv_quot[i][QW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= res_next;
            tuser_reg <= {ovf8_next, dv_side.zero};
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
            vld3_reg   <= 1'b0;
            vld4_reg   <= 1'b0;
            vld5_reg   <= 1'b0;
            vld6_reg   <= 1'b0;
            vld7_reg   <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg   <= s_axis_tvalid;
            vld2_reg   <= vld1_reg;
            vld3_reg   <= vld2_reg;
            vld4_reg   <= vld3_reg;
            vld5_reg   <= vld4_reg;
            vld6_reg   <= vld5_reg;
            vld7_reg   <= sq_vld;
            tvalid_reg <= dv_vld;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

`default_nettype wire

// ===== sv/vrn_checker.sv =====
// port-level checks for the reflect and normalise pipeline, bound to the top level
// no package dependencies
`default_nettype none

module vrn_checker
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tready,
    input  wire logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    input  wire logic [95:0]    m_axis_tdata,
    input  wire logic [1:0]     m_axis_tuser
);

    // an output beat held back stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // with nothing waiting at the output the pipe must take input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a zero-length result carries the zero vector
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 96'd0)
        else $error("zero length flagged with non-zero vector");

endmodule

bind vector_reflect_normalize_top vrn_checker u_vrn_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
